@@ hw/rtl/tilt_platform_servo_index_solver_defines.svh @@
// ---------------------------------------------------------------------------
// Tilt platform servo index solver: assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef TILT_PLATFORM_SERVO_INDEX_SOLVER_DEFINES_SVH
`define TILT_PLATFORM_SERVO_INDEX_SOLVER_DEFINES_SVH

// Same-cycle implication
`define TPSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TPSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tpsi_pkg.sv @@
// ---------------------------------------------------------------------------
// Tilt platform servo index solver: package
// Field widths, gains, fixed-point constants and the constant tangent and
// rod height tables, built at elaboration from the arm geometry.
// ---------------------------------------------------------------------------
package tpsi_pkg;

  localparam int LANES      = 3;
  localparam int TILT_W     = 7;
  localparam int TILT_MAX   = 45;
  localparam int HOME_W     = 7;
  localparam int OUT_IDX_W  = 7;
  localparam int HEIGHT_W   = 16;
  localparam int TAN_W      = 16;
  localparam int TAN_DEPTH  = 46;
  localparam int TAN_IDX_W  = 6;
  localparam int HROM_SIZE  = 256;
  localparam int HROM_IDX_W = 8;
  localparam int GAIN_W     = 15;
  localparam int PROD_W     = TAN_W + GAIN_W;
  localparam int TERM_FRAC  = 14;
  localparam int SUM_W      = 18;

  localparam logic [HOME_W-1:0] HOME_RESET = 7'd68;

  // Gains in Q12
  localparam logic [GAIN_W-1:0] GAIN_Y0  = 15'd31689;
  localparam logic [GAIN_W-1:0] GAIN_Y12 = 15'd15845;
  localparam logic [GAIN_W-1:0] GAIN_X   = 15'd27443;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (TERM_FRAC - 1);

  localparam logic signed [SUM_W-1:0] SUM_HMAX = 18'sd32767;
  localparam logic signed [SUM_W-1:0] SUM_HMIN = -18'sd32768;

  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic [TAN_W-1:0]           tan_t;
  typedef height_t                    hrom_t [HROM_SIZE];
  typedef tan_t                       trom_t [TAN_DEPTH];

  // Geometry and rotation constants (Q30 trig, Q24 lengths, Q48 rod square)
  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint COS1_Q30   = 64'sd1073578288;
  localparam longint SIN1_Q30   = 64'sd18739379;
  localparam longint ARM_Q24    = 64'sd39258685;
  localparam longint OFFS_Q24   = 64'sd68578548;
  localparam longint ROD_SQ_Q48 = 64'sd225 <<< 46;

  // Shift right, rounding half away from zero
  function automatic longint rnd_shift(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sat16(input longint v);
    if (v > 64'sd32767) return 64'sd32767;
    if (v < -64'sd32768) return -64'sd32768;
    return v;
  endfunction

  // Restoring long division, elaboration only
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | longint'(n[i]);
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Floor square root
  function automatic longint unsigned isqrt(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bit_w;
    v     = v_in;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v   = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  function automatic trom_t build_tan_rom();
    trom_t  t;
    longint c;
    longint s;
    longint nc;
    longint ns;
    c = Q30_ONE;
    s = 0;
    for (int i = 0; i < TAN_DEPTH; i++) begin
      t[i] = TAN_W'(udiv(longint'(s * 16384 + (c >>> 1)), longint'(c)));
      nc = rnd_shift(COS1_Q30 * c - SIN1_Q30 * s, 30);
      ns = rnd_shift(SIN1_Q30 * c + COS1_Q30 * s, 30);
      c  = nc;
      s  = ns;
    end
    return t;
  endfunction

  // Entry i: rod height for arm angle 270+i degrees
  function automatic hrom_t build_height_rom();
    hrom_t  h;
    longint c;
    longint s;
    longint nc;
    longint ns;
    longint ax;
    longint ay;
    longint d;
    longint arg;
    longint rod;
    c = Q30_ONE;
    s = 0;
    for (int i = 0; i < HROM_SIZE; i++) begin
      ax  = rnd_shift(ARM_Q24 * s, 30);
      ay  = -rnd_shift(ARM_Q24 * c, 30);
      d   = OFFS_Q24 - ax;
      arg = ROD_SQ_Q48 - d * d;
      if (arg < 0) arg = 0;
      rod  = longint'(isqrt(longint'(arg)));
      h[i] = HEIGHT_W'(sat16(rnd_shift(rod + ay, 12)));
      nc = rnd_shift(COS1_Q30 * c - SIN1_Q30 * s, 30);
      ns = rnd_shift(SIN1_Q30 * c + COS1_Q30 * s, 30);
      c  = nc;
      s  = ns;
    end
    return h;
  endfunction

  localparam trom_t TAN_ROM    = build_tan_rom();
  localparam hrom_t HEIGHT_ROM = build_height_rom();

endpackage

@@ hw/rtl/tpsi_tilt_if.sv @@
// ---------------------------------------------------------------------------
// Tilt word channel
// Valid/ready channel carrying the two tilt angles of one word.
// ---------------------------------------------------------------------------
interface tpsi_tilt_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tpsi_pkg::TILT_W-1:0]   tilt_x_deg;
  logic signed [tpsi_pkg::TILT_W-1:0]   tilt_y_deg;

  modport source (output valid, output tilt_x_deg, output tilt_y_deg, input ready);
  modport sink   (input valid, input tilt_x_deg, input tilt_y_deg, output ready);
endinterface

@@ hw/rtl/tpsi_servo_if.sv @@
// ---------------------------------------------------------------------------
// Servo index word channel
// Valid/ready channel carrying the three servo indices of one word.
// ---------------------------------------------------------------------------
interface tpsi_servo_if;
  logic                              valid;
  logic                              ready;
  logic [tpsi_pkg::OUT_IDX_W-1:0]    servo0_index;
  logic [tpsi_pkg::OUT_IDX_W-1:0]    servo1_index;
  logic [tpsi_pkg::OUT_IDX_W-1:0]    servo2_index;

  modport source (output valid, output servo0_index, output servo1_index,
                  output servo2_index, input ready);
  modport sink   (input valid, input servo0_index, input servo1_index,
                  input servo2_index, output ready);
endinterface

@@ hw/rtl/tpsi_height_calc.sv @@
// ---------------------------------------------------------------------------
// Target height calculator
// Three register stages: tangent and home lookup, gain products, then
// rounding, summing and saturation into the three target rod heights.
// ---------------------------------------------------------------------------
module tpsi_height_calc #(
  parameter int HEIGHT_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tpsi_pkg::TILT_W-1:0]  tilt_x,
  input  logic signed [tpsi_pkg::TILT_W-1:0]  tilt_y,
  input  logic [tpsi_pkg::HOME_W-1:0]         home_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tpsi_pkg::height_t                   out_height [tpsi_pkg::LANES]
);

  function automatic logic [tpsi_pkg::TAN_IDX_W-1:0] tilt_mag(
    input logic signed [tpsi_pkg::TILT_W-1:0] t);
    logic [tpsi_pkg::TILT_W-1:0] a;
    a = t[tpsi_pkg::TILT_W-1] ? tpsi_pkg::TILT_W'(-t) : tpsi_pkg::TILT_W'(t);
    if (a > tpsi_pkg::TILT_W'(tpsi_pkg::TILT_MAX)) begin
      return tpsi_pkg::TAN_IDX_W'(tpsi_pkg::TILT_MAX);
    end
    return tpsi_pkg::TAN_IDX_W'(a);
  endfunction

  function automatic logic signed [tpsi_pkg::SUM_W-1:0] round_term(
    input logic [tpsi_pkg::PROD_W-1:0] prod, input logic neg);
    logic [tpsi_pkg::PROD_W-1:0] r;
    logic [tpsi_pkg::SUM_W-1:0]  mag;
    r   = prod + tpsi_pkg::ROUND_HALF;
    mag = tpsi_pkg::SUM_W'(r >> tpsi_pkg::TERM_FRAC);
    return neg ? -mag : mag;
  endfunction

  function automatic tpsi_pkg::height_t sat_height(
    input logic signed [tpsi_pkg::SUM_W-1:0] v);
    if (v > tpsi_pkg::SUM_HMAX) return tpsi_pkg::HEIGHT_W'(tpsi_pkg::SUM_HMAX);
    if (v < tpsi_pkg::SUM_HMIN) return tpsi_pkg::HEIGHT_W'(tpsi_pkg::SUM_HMIN);
    return tpsi_pkg::HEIGHT_W'(v);
  endfunction

  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, v3_r;

  // stage 1
  tpsi_pkg::tan_t                     tan_x_r, tan_x_nxt;
  tpsi_pkg::tan_t                     tan_y_r, tan_y_nxt;
  logic                               neg_x_r, neg_y_r;
  tpsi_pkg::height_t                  home_r, home_nxt;
  logic [tpsi_pkg::HROM_IDX_W-1:0]    home_sel;

  // stage 2
  logic [tpsi_pkg::PROD_W-1:0]        prod_y0_r, prod_y0_nxt;
  logic [tpsi_pkg::PROD_W-1:0]        prod_y12_r, prod_y12_nxt;
  logic [tpsi_pkg::PROD_W-1:0]        prod_x_r, prod_x_nxt;
  logic                               neg_x2_r, neg_y2_r;
  tpsi_pkg::height_t                  home2_r;

  // stage 3
  logic signed [tpsi_pkg::SUM_W-1:0]  term_y0, term_y12, term_x, home_ext;
  tpsi_pkg::height_t                  h_r [tpsi_pkg::LANES];
  tpsi_pkg::height_t                  h_nxt [tpsi_pkg::LANES];

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // clamp home index to the last table entry
  always_comb begin
    if (tpsi_pkg::HROM_IDX_W'(home_index) >= HEIGHT_DEPTH) begin
      home_sel = tpsi_pkg::HROM_IDX_W'(HEIGHT_DEPTH - 1);
    end else begin
      home_sel = tpsi_pkg::HROM_IDX_W'(home_index);
    end
    tan_x_nxt = tpsi_pkg::TAN_ROM[tilt_mag(tilt_x)];
    tan_y_nxt = tpsi_pkg::TAN_ROM[tilt_mag(tilt_y)];
    home_nxt  = tpsi_pkg::HEIGHT_ROM[home_sel];
  end

  always_comb begin
    prod_y0_nxt  = tpsi_pkg::PROD_W'(tan_y_r) * tpsi_pkg::PROD_W'(tpsi_pkg::GAIN_Y0);
    prod_y12_nxt = tpsi_pkg::PROD_W'(tan_y_r) * tpsi_pkg::PROD_W'(tpsi_pkg::GAIN_Y12);
    prod_x_nxt   = tpsi_pkg::PROD_W'(tan_x_r) * tpsi_pkg::PROD_W'(tpsi_pkg::GAIN_X);
  end

  always_comb begin
    term_y0  = round_term(prod_y0_r, neg_y2_r);
    term_y12 = round_term(prod_y12_r, neg_y2_r);
    term_x   = round_term(prod_x_r, neg_x2_r);
    home_ext = tpsi_pkg::SUM_W'(home2_r);
    h_nxt[0] = sat_height(home_ext + term_y0);
    h_nxt[1] = sat_height(home_ext - term_y12 - term_x);
    h_nxt[2] = sat_height(home_ext - term_y12 + term_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      tan_x_r <= tan_x_nxt;
      tan_y_r <= tan_y_nxt;
      neg_x_r <= tilt_x[tpsi_pkg::TILT_W-1];
      neg_y_r <= tilt_y[tpsi_pkg::TILT_W-1];
      home_r  <= home_nxt;
    end
    if (rdy2) begin
      prod_y0_r  <= prod_y0_nxt;
      prod_y12_r <= prod_y12_nxt;
      prod_x_r   <= prod_x_nxt;
      neg_x2_r   <= neg_x_r;
      neg_y2_r   <= neg_y_r;
      home2_r    <= home_r;
    end
    if (rdy3) begin
      h_r <= h_nxt;
    end
  end

  assign out_valid  = v3_r;
  assign out_height = h_r;

endmodule

@@ hw/rtl/tpsi_probe_stage.sv @@
// ---------------------------------------------------------------------------
// Search probe stage
// One binary search step for each of the three lanes: probe the height
// table at the midpoint, then narrow the bounds or close the lane.
// ---------------------------------------------------------------------------
`include "tilt_platform_servo_index_solver_defines.svh"

module tpsi_probe_stage #(
  parameter int HEIGHT_DEPTH = 128,
  parameter int IDX_W        = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tpsi_pkg::height_t            in_target [tpsi_pkg::LANES],
  input  logic signed [IDX_W-1:0]      in_lo [tpsi_pkg::LANES],
  input  logic signed [IDX_W-1:0]      in_hi [tpsi_pkg::LANES],
  input  logic [tpsi_pkg::LANES-1:0]   in_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tpsi_pkg::height_t            out_target [tpsi_pkg::LANES],
  output logic signed [IDX_W-1:0]      out_lo [tpsi_pkg::LANES],
  output logic signed [IDX_W-1:0]      out_hi [tpsi_pkg::LANES],
  output logic [tpsi_pkg::LANES-1:0]   out_done
);

  logic                              valid_r;
  logic                              load;
  logic signed [IDX_W-1:0]           mid [tpsi_pkg::LANES];
  logic [tpsi_pkg::HROM_IDX_W-1:0]   rom_idx [tpsi_pkg::LANES];
  tpsi_pkg::height_t                 rom_val [tpsi_pkg::LANES];

  tpsi_pkg::height_t                 target_r [tpsi_pkg::LANES];
  logic signed [IDX_W-1:0]           lo_r [tpsi_pkg::LANES];
  logic signed [IDX_W-1:0]           lo_nxt [tpsi_pkg::LANES];
  logic signed [IDX_W-1:0]           hi_r [tpsi_pkg::LANES];
  logic signed [IDX_W-1:0]           hi_nxt [tpsi_pkg::LANES];
  logic [tpsi_pkg::LANES-1:0]        done_r, done_nxt;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < tpsi_pkg::LANES; k++) begin
      mid[k] = in_lo[k] + ((in_hi[k] - in_lo[k]) >>> 1);
      // probes past the table end read the last entry
      if (mid[k] >= HEIGHT_DEPTH) begin
        rom_idx[k] = tpsi_pkg::HROM_IDX_W'(HEIGHT_DEPTH - 1);
      end else begin
        rom_idx[k] = tpsi_pkg::HROM_IDX_W'(mid[k]);
      end
      rom_val[k]  = tpsi_pkg::HEIGHT_ROM[rom_idx[k]];
      lo_nxt[k]   = in_lo[k];
      hi_nxt[k]   = in_hi[k];
      done_nxt[k] = in_done[k];
      if (!in_done[k]) begin
        if (in_lo[k] > in_hi[k]) begin
          done_nxt[k] = 1'b1;
        end else if (mid[k] == in_lo[k]) begin
          // range down to one or two entries: take the index above the lower bound
          lo_nxt[k]   = mid[k] + IDX_W'(1);
          done_nxt[k] = 1'b1;
        end else if (rom_val[k] == in_target[k]) begin
          lo_nxt[k]   = mid[k];
          done_nxt[k] = 1'b1;
        end else if (rom_val[k] < in_target[k]) begin
          lo_nxt[k] = mid[k] + IDX_W'(1);
        end else begin
          hi_nxt[k] = mid[k] - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      target_r <= in_target;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      done_r   <= done_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_target = target_r;
  assign out_lo     = lo_r;
  assign out_hi     = hi_r;
  assign out_done   = done_r;

  for (genvar k = 0; k < tpsi_pkg::LANES; k++) begin : g_chk
    `TPSI_ASSERT_NEXT(a_done_lane_holds, clk, rst_n, load && in_done[k], done_r[k] && (lo_r[k] == $past(in_lo[k])), "closed lane changed its answer")
    `TPSI_ASSERT_NEXT(a_open_lane_shrinks, clk, rst_n, load && !in_done[k] && (in_lo[k] <= in_hi[k]), done_r[k] || ((hi_r[k] - lo_r[k]) < $past(in_hi[k] - in_lo[k])), "open lane range did not shrink")
  end

endmodule

@@ hw/rtl/tilt_platform_servo_index_solver.sv @@
// ---------------------------------------------------------------------------
// Tilt platform servo index solver
// Pipeline: the height calculator followed by
//   STEPS = clog2(SEARCH_TOP+1)+1 probe stages.
// Throughput: one word per cycle unless the output stalls; each probe stage
//   reads the constant height table once per lane, so the search chain sets the depth.
// Reset: pipeline valids cleared, home_index back to 68; tables are constant.
// ---------------------------------------------------------------------------
`include "tilt_platform_servo_index_solver_defines.svh"

module tilt_platform_servo_index_solver #(
  parameter int HEIGHT_DEPTH = 128,
  parameter int SEARCH_TOP   = 120
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tpsi_tilt_if.sink                    in_ch,
  tpsi_servo_if.source                 out_ch,
  input  logic                         cfg_wr_en,
  input  logic [tpsi_pkg::HOME_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(SEARCH_TOP + 2) + 1;
  localparam int STEPS = $clog2(SEARCH_TOP + 1) + 1;

  logic [tpsi_pkg::HOME_W-1:0]  home_index_r;

  logic                         vld_c [STEPS+1];
  logic                         rdy_c [STEPS+1];
  tpsi_pkg::height_t            tgt_c [STEPS+1][tpsi_pkg::LANES];
  logic signed [IDX_W-1:0]      lo_c [STEPS+1][tpsi_pkg::LANES];
  logic signed [IDX_W-1:0]      hi_c [STEPS+1][tpsi_pkg::LANES];
  logic [tpsi_pkg::LANES-1:0]   done_c [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_index_r <= tpsi_pkg::HOME_RESET;
    end else if (cfg_wr_en) begin
      home_index_r <= cfg_wr_data;
    end
  end

  tpsi_height_calc #(
    .HEIGHT_DEPTH (HEIGHT_DEPTH)
  ) u_height (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .tilt_x     (in_ch.tilt_x_deg),
    .tilt_y     (in_ch.tilt_y_deg),
    .home_index (home_index_r),
    .out_valid  (vld_c[0]),
    .out_ready  (rdy_c[0]),
    .out_height (tgt_c[0])
  );

  // open every lane on the search range 0 to SEARCH_TOP
  for (genvar k = 0; k < tpsi_pkg::LANES; k++) begin : g_init
    assign lo_c[0][k] = '0;
    assign hi_c[0][k] = IDX_W'(SEARCH_TOP);
  end
  assign done_c[0] = '0;

  for (genvar g = 0; g < STEPS; g++) begin : g_probe
    tpsi_probe_stage #(
      .HEIGHT_DEPTH (HEIGHT_DEPTH),
      .IDX_W        (IDX_W)
    ) u_probe (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (vld_c[g]),
      .in_ready   (rdy_c[g]),
      .in_target  (tgt_c[g]),
      .in_lo      (lo_c[g]),
      .in_hi      (hi_c[g]),
      .in_done    (done_c[g]),
      .out_valid  (vld_c[g+1]),
      .out_ready  (rdy_c[g+1]),
      .out_target (tgt_c[g+1]),
      .out_lo     (lo_c[g+1]),
      .out_hi     (hi_c[g+1]),
      .out_done   (done_c[g+1])
    );
  end

  // last probe stage registers act as the output register
  assign out_ch.valid        = vld_c[STEPS];
  assign rdy_c[STEPS]        = out_ch.ready;
  assign out_ch.servo0_index = tpsi_pkg::OUT_IDX_W'(lo_c[STEPS][0]);
  assign out_ch.servo1_index = tpsi_pkg::OUT_IDX_W'(lo_c[STEPS][1]);
  assign out_ch.servo2_index = tpsi_pkg::OUT_IDX_W'(lo_c[STEPS][2]);

  `TPSI_ASSERT_NOW(a_out_all_closed, clk, rst_n, out_ch.valid, &done_c[STEPS], "result word leaves with a search still open")

  for (genvar k = 0; k < tpsi_pkg::LANES; k++) begin : g_chk
    `TPSI_ASSERT_NOW(a_out_bounds, clk, rst_n, out_ch.valid, lo_c[STEPS][k] <= (hi_c[STEPS][k] + IDX_W'(1)), "search bounds crossed by more than one")
  end

endmodule

@@ sim/tilt_platform_servo_index_solver_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Tilt platform servo index solver: testbench
// Drives tilt words through the solver under random source gaps and sink
// stalls, predicts the three servo indices from a local build of the tangent
// and rod height tables, and compares every result word field by field.
// ---------------------------------------------------------------------------
module tilt_platform_servo_index_solver_tb;

  localparam int HEIGHT_DEPTH  = 128;
  localparam int SEARCH_TOP    = 120;
  localparam int TAN_ENTRIES   = 46;
  localparam int TILT_LIMIT    = 45;
  localparam int PIPE_LATENCY  = 11;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_TILTS  = 1650;
  localparam int RANDOM_PHASES = 6;
  localparam int MAX_GAP       = 17;

  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint COS1_Q30   = 64'sd1073578288;
  localparam longint SIN1_Q30   = 64'sd18739379;
  localparam longint ARM_Q24    = 64'sd39258685;
  localparam longint OFFS_Q24   = 64'sd68578548;
  localparam longint ROD_SQ_Q48 = 64'sd225 <<< 46;

  // Q12 gains for the three rod lifts
  localparam longint GAIN_LIFT_Y0  = 31689;
  localparam longint GAIN_LIFT_Y12 = 15845;
  localparam longint GAIN_ROLL_X   = 27443;

  typedef logic signed [tpsi_pkg::TILT_W-1:0] tilt_t;
  typedef logic [tpsi_pkg::OUT_IDX_W-1:0]     idx_t;
  typedef logic [tpsi_pkg::HOME_W-1:0]        home_t;

  localparam home_t LEVEL_HOME = 7'd68;

  typedef struct packed {
    idx_t servo0;
    idx_t servo1;
    idx_t servo2;
  } servo_word_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_wr_en;
  home_t cfg_wr_data;

  tpsi_tilt_if  tilt_ch ();
  tpsi_servo_if servo_ch ();

  tilt_platform_servo_index_solver #(
    .HEIGHT_DEPTH(HEIGHT_DEPTH),
    .SEARCH_TOP  (SEARCH_TOP)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (tilt_ch),
    .out_ch     (servo_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  longint      rod_height_q12 [HEIGHT_DEPTH];
  longint      tan_q14 [TAN_ENTRIES];
  home_t       home_shadow;
  servo_word_t pending_servo_words [$];
  bit          send_burst;
  bit          sink_burst;
  int          tilts_driven;
  int          tilts_accepted;
  int          words_checked;
  int          homes_written;
  int          error_count;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic longint round_shift(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp_height(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint height_at(input longint i);
    if (i < 0) i = 0;
    if (i >= HEIGHT_DEPTH) i = HEIGHT_DEPTH - 1;
    return rod_height_q12[i];
  endfunction

  function automatic longint tilt_term(input int deg, input longint gain);
    int     mag;
    longint t;
    mag = (deg < 0) ? -deg : deg;
    // saturate beyond the platform's travel
    if (mag > TILT_LIMIT) mag = TILT_LIMIT;
    t = tan_q14[mag];
    if (deg < 0) t = -t;
    return round_shift(t * gain, 14);
  endfunction

  function automatic idx_t locate_height(input longint target);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = SEARCH_TOP;
    while (lo <= hi) begin
      mid = (hi - lo) / 2 + lo;
      if (mid == lo) return idx_t'(mid + 1);
      if (height_at(mid) == target) return idx_t'(mid);
      if (height_at(mid) < target) lo = mid + 1;
      else hi = mid - 1;
    end
    return idx_t'(lo);
  endfunction

  function automatic servo_word_t predict_servo_word(input tilt_t x_deg, input tilt_t y_deg);
    int          tx;
    int          ty;
    longint      home;
    longint      lift_y0;
    longint      lift_y12;
    longint      roll_x;
    servo_word_t w;
    tx       = x_deg;
    ty       = y_deg;
    home     = height_at(longint'(home_shadow));
    lift_y0  = tilt_term(ty, GAIN_LIFT_Y0);
    lift_y12 = tilt_term(ty, GAIN_LIFT_Y12);
    roll_x   = tilt_term(tx, GAIN_ROLL_X);
    w.servo0 = locate_height(clamp_height(home + lift_y0));
    w.servo1 = locate_height(clamp_height(home - lift_y12 - roll_x));
    w.servo2 = locate_height(clamp_height(home - lift_y12 + roll_x));
    return w;
  endfunction

  // Tangent and rod height tables, rotating the arm in 1-degree steps
  initial begin : geometry_tables
    longint          c;
    longint          s;
    longint          nc;
    longint          ns;
    longint          ax;
    longint          ay;
    longint          d;
    longint          arg;
    longint unsigned v;
    longint unsigned res;
    longint unsigned bitv;
    c = Q30_ONE;
    s = 0;
    for (int i = 0; i < HEIGHT_DEPTH; i++) begin
      if (i < TAN_ENTRIES) tan_q14[i] = (s * 16384 + c / 2) / c;
      ax  = round_shift(ARM_Q24 * s, 30);
      ay  = -round_shift(ARM_Q24 * c, 30);
      d   = OFFS_Q24 - ax;
      arg = ROD_SQ_Q48 - d * d;
      if (arg < 0) arg = 0;
      // floor square root, two bits per step
      v    = arg;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      rod_height_q12[i] = clamp_height(round_shift(longint'(res) + ay, 12));
      nc = round_shift(COS1_Q30 * c - SIN1_Q30 * s, 30);
      ns = round_shift(SIN1_Q30 * c + COS1_Q30 * s, 30);
      c  = nc;
      s  = ns;
    end
  end

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------
  function automatic void flag_error(input string msg);
    if (error_count < 10) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endfunction

  function automatic void check_index(input string field, input idx_t want, input idx_t got);
    if (got !== want)
      flag_error($sformatf("word %0d %s expected %0d actual %0d",
                           words_checked, field, want, got));
  endfunction

  // Pop before push: a result word is always older than a word taken this edge
  always @(posedge clk) begin : servo_check
    servo_word_t want;
    if (rst_n) begin
      if (servo_ch.valid && servo_ch.ready) begin
        if (pending_servo_words.size() == 0) begin
          flag_error($sformatf("unexpected servo word %0d/%0d/%0d",
                               servo_ch.servo0_index, servo_ch.servo1_index,
                               servo_ch.servo2_index));
        end else begin
          want = pending_servo_words.pop_front();
          words_checked++;
          check_index("servo0_index", want.servo0, servo_ch.servo0_index);
          check_index("servo1_index", want.servo1, servo_ch.servo1_index);
          check_index("servo2_index", want.servo2, servo_ch.servo2_index);
        end
      end
      if (tilt_ch.valid && tilt_ch.ready) begin
        pending_servo_words.push_back(predict_servo_word(tilt_ch.tilt_x_deg,
                                                         tilt_ch.tilt_y_deg));
        tilts_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_servo_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result sink: stall a random number of cycles before each word, outside bursts
  initial begin : servo_sink
    int stall;
    int taken;
    servo_ch.ready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        servo_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      servo_ch.ready <= 1'b1;
      do @(posedge clk); while (!(servo_ch.valid && servo_ch.ready));
      taken++;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  // Leave valid high on return so back-to-back words need no extra edge
  task automatic send_tilt(input tilt_t x_deg, input tilt_t y_deg);
    int gap;
    if (tilts_driven % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      tilt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tilt_ch.valid      <= 1'b1;
    tilt_ch.tilt_x_deg <= x_deg;
    tilt_ch.tilt_y_deg <= y_deg;
    do @(posedge clk); while (!tilt_ch.ready);
    tilts_driven++;
  endtask

  // Hold the source until every predicted word has come back
  task automatic wait_servo_drain();
    tilt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_servo_words.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_home(input home_t home);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= home;
    home_shadow = home;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    homes_written++;
  endtask

  function automatic tilt_t random_tilt();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return tilt_t'($urandom_range(0, 127));
    if (pick == 1) return $urandom_range(0, 1) ? tilt_t'(TILT_LIMIT) : tilt_t'(-TILT_LIMIT);
    if (pick == 2) return tilt_t'(int'($urandom_range(0, 2)) - 1);
    return tilt_t'(int'($urandom_range(0, 2 * TILT_LIMIT)) - TILT_LIMIT);
  endfunction

  // Reset home: level, travel corners, out-of-range and 7-bit extreme tilts
  task automatic test_level_home();
    tilt_t xs [12];
    tilt_t ys [12];
    xs = '{0, 45, -45, 45, -45, 63, -64, 46, 1, 0, -45, 30};
    ys = '{0, 45, -45, -45, 45, -64, 63, -46, -1, 45, 0, -17};
    foreach (xs[i]) send_tilt(xs[i], ys[i]);
  endtask

  // Lowest and highest home entries, where the sums hit the height limits
  task automatic test_home_extremes();
    home_t homes [2];
    tilt_t xs [4];
    tilt_t ys [4];
    homes = '{7'd0, 7'd127};
    xs    = '{0, 45, -45, 45};
    ys    = '{0, 45, -45, -45};
    foreach (homes[h]) begin
      wait_servo_drain();
      write_home(homes[h]);
      foreach (xs[i]) send_tilt(xs[i], ys[i]);
    end
  endtask

  task automatic test_random_tilts();
    home_t homes [RANDOM_PHASES];
    int    per_phase;
    homes = '{LEVEL_HOME, home_t'($urandom_range(0, 127)), 7'd127, 7'd0,
              home_t'($urandom_range(1, 126)), 7'd120};
    per_phase = RANDOM_TILTS / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_servo_drain();
      write_home(homes[p]);
      for (int k = 0; k < per_phase; k++) begin
        send_tilt(random_tilt(), random_tilt());
        if (k == per_phase / 2) wait_servo_drain();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    tilt_ch.valid      = 1'b0;
    tilt_ch.tilt_x_deg = '0;
    tilt_ch.tilt_y_deg = '0;
    home_shadow        = LEVEL_HOME;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_level_home();
    test_home_extremes();
    test_random_tilts();
    wait_servo_drain();

    $display("Checked %0d servo words from %0d tilt words over %0d home settings,",
             words_checked, tilts_accepted, homes_written + 1);
    $display("tilts across the full 7-bit range under random gaps and stalls; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
